// ===== hw/rtl/jmhp_pkg.sv =====
// Package for the JPEG marker header parser: parse phases, stop reasons,
// marker codes and the result record shared by the core and the top level.
// No dependencies.
package jmhp_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned DimW    = 16;
    localparam int unsigned ReasonW = 3;

    localparam logic [ByteW-1:0] MARK_PREFIX = 8'hFF;
    localparam logic [ByteW-1:0] MARK_NONE   = 8'h00;
    localparam logic [ByteW-1:0] MARK_TEM    = 8'h01;
    localparam logic [ByteW-1:0] MARK_RST0   = 8'hD0;
    localparam logic [ByteW-1:0] MARK_SOI    = 8'hD8;
    localparam logic [ByteW-1:0] MARK_EOI    = 8'hD9;
    localparam logic [ByteW-1:0] MARK_SOS    = 8'hDA;
    localparam logic [ByteW-1:0] MARK_SOF0   = 8'hC0;
    localparam logic [ByteW-1:0] MARK_SOF2   = 8'hC2;

    localparam logic [DimW-1:0] MIN_SEG_LEN   = 16'd2;
    localparam logic [DimW-1:0] MIN_FRAME_LEN = 16'd7;

    typedef enum logic [3:0] {
        PH_PREFIX,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_PREC,
        PH_H_HI,
        PH_H_LO,
        PH_W_HI,
        PH_W_LO
    } phase_t;

    typedef enum logic [ReasonW-1:0] {
        STOP_SOS    = 3'd0,
        STOP_EOI    = 3'd1,
        STOP_NOMARK = 3'd2,
        STOP_BADLEN = 3'd3,
        STOP_END    = 3'd4
    } stop_t;

    typedef struct packed {
        logic [DimW-1:0] image_width;
        logic [DimW-1:0] image_height;
        logic            size_found;
        stop_t           stop_reason;
    } result_t;

    // Config register indexes
    localparam logic REG_WANT_SIZE = 1'b0;

endpackage

// ===== hw/rtl/jmhp_core.sv =====
// Parse state machine of the JPEG marker header parser: one stream byte per
// accepted item, emits the result record when parsing stops.
// Depends on jmhp_pkg.
module jmhp_core
    import jmhp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_accept,
    input  logic [ByteW-1:0] data_byte,
    input  logic             stream_end,
    input  logic             want_size,
    output logic             emit,
    output result_t          result
);

    phase_t          phase_reg, phase_next;
    logic [DimW-1:0] skip_left_reg, skip_left_next;
    logic [ByteW-1:0] length_high_reg, length_high_next;
    logic [DimW-1:0] width_reg, width_next;
    logic [DimW-1:0] height_reg, height_next;
    logic            found_reg, found_next;
    logic            in_frame_reg, in_frame_next;
    logic            finished_reg, finished_next;

    logic [DimW-1:0] seg_len;
    logic [DimW-1:0] skip_dec;
    logic [DimW-1:0] len_min;
    logic            standalone;
    logic            is_sof;
    logic            stop_hit;
    stop_t           reason;

    assign seg_len    = {length_high_reg, data_byte};
    assign skip_dec   = (skip_left_reg != '0) ? skip_left_reg - 1'b1 : skip_left_reg;
    assign len_min    = in_frame_reg ? MIN_FRAME_LEN : MIN_SEG_LEN;
    assign standalone = (data_byte >= MARK_RST0 && data_byte <= MARK_SOI) ||
                        (data_byte == MARK_TEM);
    assign is_sof     = (data_byte == MARK_SOF0) || (data_byte == MARK_SOF2);

    // Stop detection and result record
    always_comb begin
        stop_hit = 1'b0;
        reason   = STOP_END;
        if (stream_end) begin
            stop_hit = !finished_reg;
        end else if (!finished_reg) begin
            unique case (phase_reg)
                PH_PREFIX: begin
                    if (data_byte != MARK_PREFIX) begin
                        stop_hit = 1'b1;
                        reason   = STOP_NOMARK;
                    end
                end
                PH_MARKER: begin
                    if (data_byte == MARK_NONE) begin
                        stop_hit = 1'b1;
                        reason   = STOP_NOMARK;
                    end else if (data_byte == MARK_EOI) begin
                        stop_hit = 1'b1;
                        reason   = STOP_EOI;
                    end else if (data_byte == MARK_SOS) begin
                        stop_hit = 1'b1;
                        reason   = STOP_SOS;
                    end
                end
                PH_LEN_LO: begin
                    if (seg_len < len_min) begin
                        stop_hit = 1'b1;
                        reason   = STOP_BADLEN;
                    end
                end
                default: begin
                    stop_hit = 1'b0;
                end
            endcase
        end
    end

    assign emit                = item_accept && stop_hit;
    assign result.image_width  = found_reg ? width_reg  : '0;
    assign result.image_height = found_reg ? height_reg : '0;
    assign result.size_found   = found_reg;
    assign result.stop_reason  = reason;

    // Next state
    always_comb begin
        phase_next       = phase_reg;
        skip_left_next   = skip_left_reg;
        length_high_next = length_high_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        found_next       = found_reg;
        in_frame_next    = in_frame_reg;
        finished_next    = finished_reg;
        if (stream_end) begin
            // rearm for the next image
            phase_next       = PH_PREFIX;
            skip_left_next   = '0;
            length_high_next = '0;
            width_next       = '0;
            height_next      = '0;
            found_next       = 1'b0;
            in_frame_next    = 1'b0;
            finished_next    = 1'b0;
        end else if (!finished_reg) begin
            if (stop_hit) begin
                finished_next = 1'b1;
                in_frame_next = 1'b0;
            end else begin
                unique case (phase_reg)
                    PH_PREFIX: phase_next = PH_MARKER;
                    PH_MARKER: begin
                        // fill bytes keep us here
                        if (data_byte != MARK_PREFIX) begin
                            if (standalone) begin
                                phase_next = PH_PREFIX;
                            end else begin
                                in_frame_next = want_size && !found_reg && is_sof;
                                phase_next    = PH_LEN_HI;
                            end
                        end
                    end
                    PH_LEN_HI: begin
                        length_high_next = data_byte;
                        phase_next       = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        skip_left_next = seg_len - MIN_SEG_LEN;
                        if (in_frame_reg) begin
                            in_frame_next = 1'b0;
                            phase_next    = PH_PREC;
                        end else if (seg_len == MIN_SEG_LEN) begin
                            phase_next = PH_PREFIX;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        skip_left_next = skip_dec;
                        if (skip_dec == '0) begin
                            phase_next = PH_PREFIX;
                        end
                    end
                    PH_PREC: begin
                        skip_left_next = skip_dec;
                        phase_next     = PH_H_HI;
                    end
                    PH_H_HI: begin
                        skip_left_next   = skip_dec;
                        length_high_next = data_byte;
                        phase_next       = PH_H_LO;
                    end
                    PH_H_LO: begin
                        skip_left_next = skip_dec;
                        height_next    = seg_len;
                        phase_next     = PH_W_HI;
                    end
                    PH_W_HI: begin
                        skip_left_next   = skip_dec;
                        length_high_next = data_byte;
                        phase_next       = PH_W_LO;
                    end
                    PH_W_LO: begin
                        skip_left_next = skip_dec;
                        width_next     = seg_len;
                        found_next     = 1'b1;
                        phase_next     = (skip_dec == '0) ? PH_PREFIX : PH_SKIP;
                    end
                    default: phase_next = PH_PREFIX;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_PREFIX;
            skip_left_reg   <= '0;
            length_high_reg <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            found_reg       <= 1'b0;
            in_frame_reg    <= 1'b0;
            finished_reg    <= 1'b0;
        end else if (item_accept) begin
            phase_reg       <= phase_next;
            skip_left_reg   <= skip_left_next;
            length_high_reg <= length_high_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            found_reg       <= found_next;
            in_frame_reg    <= in_frame_next;
            finished_reg    <= finished_next;
        end
    end

endmodule

// ===== hw/rtl/jpeg_marker_header_parser.sv =====
// Top level of the JPEG marker header parser: stream ports, config register,
// output register. Depends on jmhp_pkg and jmhp_core.
//
//   channel   dir  payload                                         accepted when
//   s_        in   tdata: data_byte[7:0]; tlast: stream_end         s_tvalid & s_tready
//   m_        out  tdata: width, height, size_found; tuser: reason  m_tvalid & m_tready
//   apb       in   reg 0 at 0x0: want_size (bit 0)                  psel&penable&pwrite
//
// One byte per cycle while s_tready is high; the state machine updates on each
// accepted item and a stop result lands in the output register at the same edge.
// s_tready stays high while the output register is empty or being taken,
// so a waiting result stalls input only when m_tready is low.
// Reset is synchronous (aresetn low): parser rearmed, want_size set to 1.
module jpeg_marker_header_parser
    import jmhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // stream_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] image_width, [31:16] image_height,
                                   // [32] size_found, [39:33] zero
    output logic [2:0]  m_tuser,   // stop_reason
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic    want_size_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    accept;
    logic    emit;
    result_t result;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_WANT_SIZE) ? {31'd0, want_size_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            want_size_reg <= 1'b1;
        end else if (cfg_write && paddr[2] == REG_WANT_SIZE) begin
            want_size_reg <= pwdata[0];
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    jmhp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (accept),
        .data_byte   (s_tdata),
        .stream_end  (s_tlast),
        .want_size   (want_size_reg),
        .emit        (emit),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg.size_found, out_data_reg.image_height,
                       out_data_reg.image_width};
    assign m_tuser  = out_data_reg.stop_reason;

endmodule
